// File: rtl/core/acd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// acd_pkg
// Shared types, constants and AES-128 round functions for the CTR-DRBG block.
// ----------------------------------------------------------------------------
package acd_pkg;

	localparam int MAX_REQUEST_BYTES = 1024;
	localparam int REQ_W             = 11;
	localparam int BLOCK_BYTES       = 16;
	localparam logic [7:0] RESEED_INTERVAL_RESET = 8'd16;

	typedef struct packed {
		logic             func;
		logic [63:0]      entropy_0;
		logic [63:0]      entropy_1;
		logic [63:0]      entropy_2;
		logic [63:0]      entropy_3;
		logic [REQ_W-1:0] request_bytes;
	} in_item_t;

	typedef struct packed {
		logic [63:0] out_low;
		logic [63:0] out_high;
		logic [4:0]  valid_bytes;
		logic        last;
	} out_item_t;

	localparam logic FUNC_INSTANTIATE = 1'b0;
	localparam logic FUNC_GENERATE    = 1'b1;

	localparam logic [7:0] SBOX [256] = '{
		8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
		8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
		8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
		8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
		8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
		8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
		8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
		8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
		8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
		8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
		8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
		8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
		8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
		8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
		8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
		8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16
	};

	function automatic logic [7:0] rcon(input logic [3:0] rnd);
		logic [7:0] rc;
		case (rnd)
			4'd1:    rc = 8'h01;
			4'd2:    rc = 8'h02;
			4'd3:    rc = 8'h04;
			4'd4:    rc = 8'h08;
			4'd5:    rc = 8'h10;
			4'd6:    rc = 8'h20;
			4'd7:    rc = 8'h40;
			4'd8:    rc = 8'h80;
			4'd9:    rc = 8'h1B;
			4'd10:   rc = 8'h36;
			default: rc = 8'h00;
		endcase
		return rc;
	endfunction

	function automatic logic [7:0] xtime(input logic [7:0] b);
		return {b[6:0], 1'b0} ^ (b[7] ? 8'h1B : 8'h00);
	endfunction

	// byte i of a 128-bit word sits in bits 8i+7:8i; state index = row + 4*col
	function automatic logic [127:0] sub_shift(input logic [127:0] s);
		logic [127:0] t;
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				t[8*(r+4*c) +: 8] = SBOX[s[8*(r+4*((c+r)%4)) +: 8]];
			end
		end
		return t;
	endfunction

	function automatic logic [127:0] mix_columns(input logic [127:0] t);
		logic [127:0] m;
		logic [7:0]   a0, a1, a2, a3, all;
		for (int c = 0; c < 4; c++) begin
			a0  = t[32*c +: 8];
			a1  = t[32*c+8 +: 8];
			a2  = t[32*c+16 +: 8];
			a3  = t[32*c+24 +: 8];
			all = a0 ^ a1 ^ a2 ^ a3;
			m[32*c +: 8]    = a0 ^ all ^ xtime(a0 ^ a1);
			m[32*c+8 +: 8]  = a1 ^ all ^ xtime(a1 ^ a2);
			m[32*c+16 +: 8] = a2 ^ all ^ xtime(a2 ^ a3);
			m[32*c+24 +: 8] = a3 ^ all ^ xtime(a3 ^ a0);
		end
		return m;
	endfunction

	function automatic logic [127:0] key_step(input logic [127:0] p, input logic [7:0] rc);
		logic [127:0] q;
		q[7:0]   = p[7:0]   ^ SBOX[p[111:104]] ^ rc;
		q[15:8]  = p[15:8]  ^ SBOX[p[119:112]];
		q[23:16] = p[23:16] ^ SBOX[p[127:120]];
		q[31:24] = p[31:24] ^ SBOX[p[103:96]];
		for (int j = 4; j < 16; j++) begin
			q[8*j +: 8] = p[8*j +: 8] ^ q[8*(j-4) +: 8];
		end
		return q;
	endfunction

endpackage
`default_nettype wire

// File: rtl/core/acd_aes_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// acd_aes_core
// Iterative AES-128 encryption: one round per cycle, round keys on the fly.
// ----------------------------------------------------------------------------
module acd_aes_core (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         start,
	input  wire logic [127:0] key,
	input  wire logic [127:0] block,
	output logic              done,
	output logic [127:0]      result
);
	import acd_pkg::*;

	logic [127:0] state_q, rkey_q, rk_next, sb, rnd_out;
	logic [3:0]   round_q;
	logic         busy_q;

	always_comb begin
		rk_next = key_step(rkey_q, rcon(round_q));
		sb      = sub_shift(state_q);
		rnd_out = ((round_q == 4'd10) ? sb : mix_columns(sb)) ^ rk_next;
		done    = busy_q && (round_q == 4'd10);
		result  = rnd_out;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			round_q <= 4'd0;
		end else if (start) begin
			busy_q  <= 1'b1;
			round_q <= 4'd1;
		end else if (busy_q) begin
			round_q <= round_q + 4'd1;
			if (round_q == 4'd10) busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			state_q <= block ^ key;
			rkey_q  <= key;
		end else if (busy_q) begin
			state_q <= rnd_out;
			rkey_q  <= rk_next;
		end
	end

endmodule
`default_nettype wire

// File: rtl/core/aes128_ctr_drbg_generator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// aes128_ctr_drbg_generator
// CTR-DRBG on AES-128 without derivation function, one shared AES round unit.
// ----------------------------------------------------------------------------
// One transaction at a time; input stall stays high until the item is
// finished, closing update included. All work runs through one AES core doing
// one round per cycle. An update costs two encryptions. An instantiate runs
// one update and then its acknowledgment. A generate runs an update if it
// reseeds, one encryption per 16-byte block and the closing update, and any
// output stall holds it.
module aes128_ctr_drbg_generator (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire acd_pkg::in_item_t  in_item,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output acd_pkg::out_item_t      out_item,
	input  wire logic               cfg_we,
	input  wire logic [7:0]         cfg_data
);
	import acd_pkg::*;

	typedef enum logic [7:0] {
		S_IDLE  = 8'b0000_0001,
		S_PREP  = 8'b0000_0010,
		S_UPD1  = 8'b0000_0100,
		S_UPD2  = 8'b0000_1000,
		S_GNEXT = 8'b0001_0000,
		S_GEN   = 8'b0010_0000,
		S_OUT   = 8'b0100_0000,
		S_ACK   = 8'b1000_0000
	} state_t;

	state_t           state_q;
	logic [127:0]     key_q, v_q, nk_q, v_inc, aes_blk, aes_res, upd_data_lo, upd_data_hi;
	logic [255:0]     data_q;
	logic [REQ_W-1:0] rem_q, req_sat;
	logic [8:0]       count_q;
	logic [7:0]       interval_q;
	logic             func_q, zero_req_q, final_q;
	logic             aes_start, blk_inc, aes_done, reseed_need;
	logic [4:0]       vb;
	logic [127:0]     masked;
	out_item_t        out_q;

	acd_aes_core u_aes (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (aes_start),
		.key    (key_q),
		.block  (aes_blk),
		.done   (aes_done),
		.result (aes_res)
	);

	always_comb begin
		v_inc       = v_q + 128'd1;
		reseed_need = (func_q == FUNC_INSTANTIATE) || (count_q > {1'b0, interval_q});
		req_sat     = (in_item.request_bytes > REQ_W'(MAX_REQUEST_BYTES)) ?
		              REQ_W'(MAX_REQUEST_BYTES) : in_item.request_bytes;
		vb          = (rem_q >= REQ_W'(BLOCK_BYTES)) ? 5'd16 : rem_q[4:0];
		upd_data_lo = final_q ? 128'd0 : data_q[127:0];
		upd_data_hi = final_q ? 128'd0 : data_q[255:128];
		for (int i = 0; i < 16; i++) begin
			masked[8*i +: 8] = (5'(i) < vb) ? aes_res[8*i +: 8] : 8'h00;
		end
		aes_start = 1'b0;
		blk_inc   = 1'b0;
		case (state_q)
			S_PREP:  aes_start = reseed_need;
			S_UPD1: begin
				aes_start = aes_done;
				blk_inc   = 1'b1;
			end
			S_GNEXT: begin
				aes_start = 1'b1;
				blk_inc   = (rem_q != '0);
			end
			default: ;
		endcase
		aes_blk   = blk_inc ? v_inc : v_q;
		in_stall  = (state_q != S_IDLE);
		out_valid = (state_q == S_OUT) || (state_q == S_ACK);
		out_item  = out_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q <= RESEED_INTERVAL_RESET;
		end else if (cfg_we) begin
			interval_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			key_q      <= '0;
			v_q        <= '0;
			count_q    <= '0;
			func_q     <= 1'b0;
			zero_req_q <= 1'b0;
			final_q    <= 1'b0;
			rem_q      <= '0;
		end else begin
			case (state_q)
				S_IDLE: if (in_valid) begin
					func_q     <= in_item.func;
					rem_q      <= req_sat;
					zero_req_q <= (in_item.request_bytes == '0);
					if (in_item.func == FUNC_INSTANTIATE) begin
						key_q <= '0;
						v_q   <= '0;
					end
					state_q <= S_PREP;
				end
				S_PREP: begin
					final_q <= 1'b0;
					state_q <= reseed_need ? S_UPD1 : S_GNEXT;
				end
				S_UPD1: if (aes_done) begin
					v_q     <= v_inc;
					state_q <= S_UPD2;
				end
				S_UPD2: if (aes_done) begin
					key_q <= nk_q ^ upd_data_lo;
					v_q   <= aes_res ^ upd_data_hi;
					if (final_q) begin
						count_q <= count_q + 9'd1;
						state_q <= zero_req_q ? S_ACK : S_IDLE;
					end else begin
						count_q <= 9'd1;
						state_q <= (func_q == FUNC_GENERATE) ? S_GNEXT : S_ACK;
					end
				end
				S_GNEXT: begin
					if (rem_q == '0) begin
						final_q <= 1'b1;
						state_q <= S_UPD1;
					end else begin
						v_q     <= v_inc;
						state_q <= S_GEN;
					end
				end
				S_GEN: if (aes_done) state_q <= S_OUT;
				S_OUT: if (!out_stall) begin
					rem_q   <= rem_q - REQ_W'(vb);
					state_q <= S_GNEXT;
				end
				S_ACK: if (!out_stall) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if ((state_q == S_UPD1) && aes_done) nk_q <= aes_res;
		if (state_q == S_IDLE && in_valid) begin
			data_q <= {in_item.entropy_3, in_item.entropy_2,
			           in_item.entropy_1, in_item.entropy_0};
		end
		if ((state_q == S_GEN) && aes_done) begin
			out_q.out_low     <= masked[63:0];
			out_q.out_high    <= masked[127:64];
			out_q.valid_bytes <= vb;
			out_q.last        <= (rem_q <= REQ_W'(BLOCK_BYTES));
		end else if ((state_q == S_UPD2) && aes_done) begin
			// acknowledgment for instantiate or an empty request
			out_q.out_low     <= '0;
			out_q.out_high    <= '0;
			out_q.valid_bytes <= 5'd0;
			out_q.last        <= 1'b1;
		end
	end

endmodule
`default_nettype wire
